FILE: hw/rtl/c_source_noise_blanker_assert.svh
// Assertion macros for the C source noise blanker.
// Included by the modules that check their own logic; needs clk and rst_n in scope.
`ifndef C_SOURCE_NOISE_BLANKER_ASSERT_SVH
`define C_SOURCE_NOISE_BLANKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CNB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CNB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cnb_pkg.sv
// Shared types and constants of the C source noise blanker.
// No dependencies; every other file but cnb_in_if and the assert macros imports this package.
`default_nettype none

package cnb_pkg;

    // Leading blank buffer and line counter sizes.
    localparam int INDENT_DEPTH = 32;
    localparam int IDX_W        = $clog2(INDENT_DEPTH);
    localparam int CNT_W        = $clog2(INDENT_DEPTH + 1);
    localparam int LINE_BITS    = 20;
    localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};

    // Command queue between the lexer and the line stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    // Lexer modes.
    typedef enum logic [2:0] {
        LEX_TEXT,
        LEX_LINECMT,
        LEX_BLOCK,
        LEX_STAR,
        LEX_STR,
        LEX_ESC
    } lex_mode_t;

    // Line stage sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_END,
        BK_FIN
    } back_state_t;

    // One classified input byte: up to two symbols for the line stage.
    typedef struct packed {
        logic [1:0]           n;
        logic [7:0]           sym0;
        logic [7:0]           sym1;
        logic                 last;
        logic                 open_cmt;
        logic [LINE_BITS-1:0] eline;
    } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cnb_in_if.sv
// Input channel of the noise blanker: one source byte per transfer.
// Standalone interface, no package dependency.
`default_nettype none

interface cnb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, in_byte, end_of_text, input ready);
    modport sink (input valid, in_byte, end_of_text, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cnb_out_if.sv
// Output channel of the noise blanker: one result per transfer.
// Depends on cnb_pkg for the line number width.
`default_nettype none

interface cnb_out_if;
    import cnb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [7:0]           out_byte;
    logic                 has_byte;
    logic                 run_end;
    logic                 open_comment_error;
    logic [LINE_BITS-1:0] error_line;

    modport source (output valid, out_byte, has_byte, run_end, open_comment_error,
                    error_line, input ready);
    modport sink (input valid, out_byte, has_byte, run_end, open_comment_error,
                  error_line, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cnb_front.sv
// Front end: accepts source bytes, runs the comment and literal lexer and
// turns each byte into a line stage command. Depends on cnb_pkg and cnb_in_if.
`default_nettype none

module cnb_front (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cnb_in_if.sink      text_in,
    output cnb_pkg::cmd_t cmd,
    output logic        cmd_valid,
    input  wire logic   cmd_ready
);
    import cnb_pkg::*;

    lex_mode_t            mode_reg, mode_next;
    logic                 qs_reg, qs_next;
    logic                 held_reg, held_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LINE_BITS-1:0] start_reg, start_next;

    logic [7:0] c;
    logic       is_nl;
    logic       done;
    logic [1:0] n_v;
    logic [7:0] sym_v [2];
    logic       open_v;
    logic       accept;

    assign c      = text_in.in_byte;
    assign is_nl  = (c == CH_NL);
    assign accept = text_in.valid && cmd_ready;

    // The queue takes a command whenever it has room.
    assign text_in.ready = cmd_ready;

    // Lexer: next mode and the symbols handed to the line stage.
    always_comb
    begin
        mode_next  = mode_reg;
        qs_next    = qs_reg;
        held_next  = held_reg;
        line_next  = line_reg;
        start_next = start_reg;
        n_v        = 2'd0;
        sym_v[0]   = CH_SPACE;
        sym_v[1]   = CH_SPACE;
        done       = 1'b0;
        open_v     = 1'b0;

        case (mode_reg)
            LEX_LINECMT:
            begin
                if (is_nl)
                begin
                    sym_v[n_v[0]] = CH_NL;
                    mode_next     = LEX_TEXT;
                end
                else
                begin
                    sym_v[n_v[0]] = CH_SPACE;
                end
                n_v = n_v + 2'd1;
            end
            LEX_BLOCK, LEX_STAR:
            begin
                if (is_nl)
                begin
                    sym_v[n_v[0]] = CH_NL;
                    mode_next     = LEX_BLOCK;
                end
                else
                begin
                    sym_v[n_v[0]] = CH_SPACE;
                    if (c == CH_STAR)
                        mode_next = LEX_STAR;
                    else if (c == CH_SLASH && mode_reg == LEX_STAR)
                        mode_next = LEX_TEXT;
                    else
                        mode_next = LEX_BLOCK;
                end
                n_v = n_v + 2'd1;
            end
            LEX_STR:
            begin
                if (is_nl)
                begin
                    sym_v[n_v[0]] = CH_NL;
                end
                else if (c == CH_BSLASH)
                begin
                    sym_v[n_v[0]] = CH_SPACE;
                    mode_next     = LEX_ESC;
                end
                else if (c == (qs_reg ? CH_SQUOTE : CH_DQUOTE))
                begin
                    sym_v[n_v[0]] = c;
                    mode_next     = LEX_TEXT;
                end
                else
                begin
                    sym_v[n_v[0]] = CH_SPACE;
                end
                n_v = n_v + 2'd1;
            end
            LEX_ESC:
            begin
                sym_v[n_v[0]] = is_nl ? CH_NL : CH_SPACE;
                n_v           = n_v + 2'd1;
                mode_next     = LEX_STR;
            end
            default:
            begin
                mode_next = LEX_TEXT;
                // A held slash either opens a comment or goes out as itself.
                if (held_reg)
                begin
                    held_next = 1'b0;
                    if (c == CH_SLASH || c == CH_STAR)
                    begin
                        sym_v[0]  = CH_SPACE;
                        sym_v[1]  = CH_SPACE;
                        n_v       = 2'd2;
                        done      = 1'b1;
                        if (c == CH_SLASH)
                        begin
                            mode_next = LEX_LINECMT;
                        end
                        else
                        begin
                            mode_next  = LEX_BLOCK;
                            start_next = line_reg;
                        end
                    end
                    else
                    begin
                        sym_v[n_v[0]] = CH_SLASH;
                        n_v           = n_v + 2'd1;
                    end
                end
                if (!done)
                begin
                    if (c == CH_SLASH)
                    begin
                        held_next = 1'b1;
                    end
                    else if (c inside {CH_DQUOTE, CH_SQUOTE})
                    begin
                        qs_next       = (c == CH_SQUOTE);
                        sym_v[n_v[0]] = c;
                        n_v           = n_v + 2'd1;
                        mode_next     = LEX_STR;
                    end
                    else
                    begin
                        sym_v[n_v[0]] = c;
                        n_v           = n_v + 2'd1;
                    end
                end
            end
        endcase

        // Saturating line counter.
        if (is_nl && line_reg != LINE_TOP)
            line_next = line_reg + 1'b1;

        open_v = mode_next inside {LEX_BLOCK, LEX_STAR};

        // End of text: release a held slash and return to the reset state.
        if (text_in.end_of_text)
        begin
            if (held_next)
            begin
                sym_v[n_v[0]] = CH_SLASH;
                n_v           = n_v + 2'd1;
            end
            mode_next  = LEX_TEXT;
            qs_next    = 1'b0;
            held_next  = 1'b0;
            line_next  = LINE_BITS'(1);
            start_next = '0;
        end
    end

    // Command toward the line stage; bytes that give nothing are dropped.
    always_comb
    begin
        cmd.n        = n_v;
        cmd.sym0     = sym_v[0];
        cmd.sym1     = sym_v[1];
        cmd.last     = text_in.end_of_text;
        cmd.open_cmt = open_v;
        cmd.eline    = start_reg;
        if (mode_reg == LEX_TEXT && held_reg && c == CH_STAR)
            cmd.eline = line_reg;
        cmd_valid    = text_in.valid && (n_v != 2'd0 || text_in.end_of_text);
    end

    // Lexer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= LEX_TEXT;
            qs_reg    <= 1'b0;
            held_reg  <= 1'b0;
            line_reg  <= LINE_BITS'(1);
            start_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            qs_reg    <= qs_next;
            held_reg  <= held_next;
            line_reg  <= line_next;
            start_reg <= start_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cnb_queue.sv
// Short command queue between the lexer and the line stage.
// Depends on cnb_pkg for the command type and depth.
`default_nettype none

module cnb_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cnb_pkg::cmd_t push_data,
    input  wire logic          push_valid,
    output logic               push_ready,
    output cnb_pkg::cmd_t      pop_data,
    output logic               pop_valid,
    input  wire logic          pop_ready
);
    import cnb_pkg::*;

    cmd_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = q_mem[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_reg] <= push_data;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cnb_back.sv
// Back end: line stage that buffers leading blanks, blanks directive lines
// and sends results one per transfer. Depends on cnb_pkg, cnb_out_if and the assert macros.
`default_nettype none
`include "c_source_noise_blanker_assert.svh"

module cnb_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cnb_pkg::cmd_t cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    cnb_out_if.source          text_out
);
    import cnb_pkg::*;

    back_state_t          st_reg, st_next;
    cmd_t                 cur_reg, cur_next;
    logic                 idx_reg, idx_next;
    logic [CNT_W-1:0]     fptr_reg, fptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 lead_reg, lead_next;
    logic                 dir_reg, dir_next;
    logic [INDENT_DEPTH-1:0] tab_reg;
    logic                 pend_valid_reg, pend_valid_next;
    logic [7:0]           pend_byte_reg, pend_byte_next;

    logic                 ov_reg, ov_next;
    logic [7:0]           ob_reg, ob_next;
    logic                 oh_reg, oh_next;
    logic                 ore_reg, ore_next;
    logic                 oerr_reg, oerr_next;
    logic [LINE_BITS-1:0] oline_reg, oline_next;

    logic       out_free;
    logic [7:0] sym;
    logic       s_blank;
    logic       act_store, act_flush, act_fspace;
    logic [7:0] emit_byte;
    logic       as_space;
    logic [7:0] blank_byte;
    logic       produce;
    logic [7:0] prod_byte;
    logic       fin_push;
    logic       tab_we;

    assign out_free = !ov_reg || text_out.ready;
    assign sym      = idx_reg ? cur_reg.sym1 : cur_reg.sym0;
    assign s_blank  = (sym == CH_SPACE) || (sym == CH_TAB);

    // Classify the current symbol against the line state.
    always_comb
    begin
        act_store  = 1'b0;
        act_flush  = 1'b0;
        act_fspace = 1'b0;
        emit_byte  = sym;
        if (sym == CH_NL)
        begin
            act_flush = 1'b1;
        end
        else if (dir_reg)
        begin
            emit_byte = CH_SPACE;
        end
        else if (lead_reg && s_blank && cnt_reg < CNT_W'(INDENT_DEPTH))
        begin
            act_store = 1'b1;
        end
        else if (lead_reg && sym == CH_HASH)
        begin
            act_flush  = 1'b1;
            act_fspace = 1'b1;
            emit_byte  = CH_SPACE;
        end
        else if (lead_reg)
        begin
            act_flush = 1'b1;
        end
    end

    // Replayed blank at the flush pointer.
    assign as_space   = (st_reg == BK_RUN) && act_fspace;
    assign blank_byte = (as_space || !tab_reg[fptr_reg[IDX_W-1:0]]) ? CH_SPACE : CH_TAB;

    // Line stage sequencer.
    always_comb
    begin
        st_next   = st_reg;
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        fptr_next = fptr_reg;
        cnt_next  = cnt_reg;
        lead_next = lead_reg;
        dir_next  = dir_reg;
        cmd_ready = 1'b0;
        produce   = 1'b0;
        prod_byte = CH_SPACE;
        fin_push  = 1'b0;
        tab_we    = 1'b0;

        case (st_reg)
            BK_RUN:
            begin
                if (out_free)
                begin
                    if (act_store)
                    begin
                        tab_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else if (act_flush && fptr_reg < cnt_reg)
                    begin
                        produce   = 1'b1;
                        prod_byte = blank_byte;
                        fptr_next = fptr_reg + 1'b1;
                    end
                    else
                    begin
                        produce   = 1'b1;
                        prod_byte = emit_byte;
                        fptr_next = '0;
                        if (act_flush)
                            cnt_next = '0;
                        if (sym == CH_NL)
                        begin
                            lead_next = 1'b1;
                            dir_next  = 1'b0;
                        end
                        else if (lead_reg && !dir_reg && sym == CH_HASH)
                        begin
                            lead_next = 1'b0;
                            dir_next  = 1'b1;
                        end
                        else if (lead_reg && !dir_reg && !s_blank)
                        begin
                            lead_next = 1'b0;
                        end
                    end
                    // Step to the second symbol or to the end of the command.
                    if (!(act_flush && fptr_reg < cnt_reg))
                    begin
                        if (!idx_reg && cur_reg.n == 2'd2)
                            idx_next = 1'b1;
                        else
                            st_next = BK_END;
                    end
                end
            end
            BK_END:
            begin
                if (out_free)
                begin
                    if (cur_reg.last && fptr_reg < cnt_reg)
                    begin
                        produce   = 1'b1;
                        prod_byte = blank_byte;
                        fptr_next = fptr_reg + 1'b1;
                    end
                    else
                    begin
                        st_next = BK_FIN;
                    end
                end
            end
            BK_FIN:
            begin
                if (out_free)
                begin
                    fin_push = pend_valid_reg || cur_reg.last;
                    if (cur_reg.last)
                    begin
                        lead_next = 1'b1;
                        dir_next  = 1'b0;
                        cnt_next  = '0;
                        fptr_next = '0;
                    end
                    cmd_ready = 1'b1;
                    st_next   = BK_IDLE;
                    if (cmd_valid)
                    begin
                        cur_next  = cmd;
                        idx_next  = 1'b0;
                        fptr_next = '0;
                        st_next   = (cmd.n == 2'd0) ? BK_END : BK_RUN;
                    end
                end
            end
            default:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cur_next  = cmd;
                    idx_next  = 1'b0;
                    fptr_next = '0;
                    st_next   = (cmd.n == 2'd0) ? BK_END : BK_RUN;
                end
            end
        endcase
    end

    // Pending result and output register: a result goes out once the next one,
    // or the end of its command, is known.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        ov_next         = ov_reg;
        ob_next         = ob_reg;
        oh_next         = oh_reg;
        ore_next        = ore_reg;
        oerr_next       = oerr_reg;
        oline_next      = oline_reg;
        if (out_free)
        begin
            ov_next = 1'b0;
            if (produce)
            begin
                pend_valid_next = 1'b1;
                pend_byte_next  = prod_byte;
                if (pend_valid_reg)
                begin
                    ov_next    = 1'b1;
                    ob_next    = pend_byte_reg;
                    oh_next    = 1'b1;
                    ore_next   = 1'b0;
                    oerr_next  = 1'b0;
                    oline_next = '0;
                end
            end
            else if (st_reg == BK_FIN)
            begin
                pend_valid_next = 1'b0;
                if (fin_push)
                begin
                    ov_next    = 1'b1;
                    ob_next    = pend_valid_reg ? pend_byte_reg : 8'h00;
                    oh_next    = pend_valid_reg;
                    ore_next   = 1'b1;
                    oerr_next  = cur_reg.last && cur_reg.open_cmt;
                    oline_next = (cur_reg.last && cur_reg.open_cmt) ? cur_reg.eline : '0;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= BK_IDLE;
            idx_reg        <= 1'b0;
            fptr_reg       <= '0;
            cnt_reg        <= '0;
            lead_reg       <= 1'b1;
            dir_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            idx_reg        <= idx_next;
            fptr_reg       <= fptr_next;
            cnt_reg        <= cnt_next;
            lead_reg       <= lead_next;
            dir_reg        <= dir_next;
            pend_valid_reg <= pend_valid_next;
            ov_reg         <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        pend_byte_reg <= pend_byte_next;
        ob_reg        <= ob_next;
        oh_reg        <= oh_next;
        ore_reg       <= ore_next;
        oerr_reg      <= oerr_next;
        oline_reg     <= oline_next;
    end

    // Leading blank buffer: one bit per blank, set for a tab.
    always_ff @(posedge clk)
    begin
        if (tab_we)
            tab_reg[cnt_reg[IDX_W-1:0]] <= (sym == CH_TAB);
    end

    // Output channel.
    assign text_out.valid              = ov_reg;
    assign text_out.out_byte           = ob_reg;
    assign text_out.has_byte           = oh_reg;
    assign text_out.run_end            = ore_reg;
    assign text_out.open_comment_error = oerr_reg;
    assign text_out.error_line         = oline_reg;

    // Checks on the line stage bookkeeping and result framing.
    `CNB_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(INDENT_DEPTH), "blank count overflow")
    `CNB_ASSERT_IMPL(a_fptr_bound, 1'b1, fptr_reg <= cnt_reg, "flush pointer past blank count")
    `CNB_ASSERT_IMPL(a_dir_empty, dir_reg, cnt_reg == '0, "blanks buffered on directive line")
    `CNB_ASSERT_IMPL(a_err_last, ov_reg && oerr_reg, ore_reg, "comment error not on last result")
    `CNB_ASSERT_IMPL(a_empty_last, ov_reg && !oh_reg, ore_reg, "byteless result not last")

endmodule

`default_nettype wire

FILE: hw/rtl/c_source_noise_blanker.sv
// Throughput: the lexer takes one byte per cycle into a four-entry command queue while the queue
// has room; the line stage takes one command at a time, steps through its symbols, replays buffered
// blanks and passes its end and finish states, holding whenever the output is stalled.
// Reset: asynchronous, active low; clears lexer, queue, line state and output valid.
// End of text returns the lexer and line state to their reset values for the next text.
`default_nettype none

module c_source_noise_blanker (
    input  wire logic clk,
    input  wire logic rst_n,
    cnb_in_if.sink    text_in,
    cnb_out_if.source text_out
);
    import cnb_pkg::*;

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t back_cmd;
    logic back_valid;
    logic back_ready;

    // Lexer and command classification.
    cnb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    // Decoupling queue.
    cnb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (back_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    // Line stage and result output.
    cnb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .text_out  (text_out)
    );

endmodule

`default_nettype wire

FILE: tb/sv/c_source_noise_blanker_test.sv
// Self-checking bench for c_source_noise_blanker: C-like text in, blanked text out.
// A behavioral model of the blanker predicts every result transfer; needs cnb_pkg,
// cnb_in_if, cnb_out_if and the RTL of the block.
module c_source_noise_blanker_test;
    import cnb_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 470;
    localparam int DRAIN_CYCLES   = 40;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int STALL_CYCLES   = 300;
    localparam int STALL_FIRST    = 150;
    localparam int STALL_SECOND   = 380;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_CR   = 8'h0D;

    // One result transfer as the blanker should produce it.
    typedef struct packed {
        logic [7:0]           out_byte;
        logic                 has_byte;
        logic                 run_end;
        logic                 open_comment_error;
        logic [LINE_BITS-1:0] error_line;
    } blanked_t;

    // One source byte waiting to be offered.
    typedef struct {
        logic [7:0] text_byte;
        logic       last;
        bit         wait_idle;
    } source_byte_t;

    logic clk;
    logic rst_n;

    cnb_in_if  text_in ();
    cnb_out_if text_out ();

    c_source_noise_blanker u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .text_out (text_out)
    );

    source_byte_t source_q[$];
    blanked_t     blanked_q[$];
    source_byte_t sent;
    bit           next_idle;
    bit           in_fire;
    bit           out_fire;
    int           inputs_taken;
    int           error_count;
    int           src_gap;
    bit           src_burst;
    int           sink_gap;
    bit           sink_burst;
    int           stall_left;
    int           stall_idx;

    // Model state: lexer, line stage and the leading blank buffer.
    lex_mode_t              lex_state;
    bit                     quote_single;
    bit                     slash_pending;
    logic [LINE_BITS-1:0]   line_no;
    logic [LINE_BITS-1:0]   cmt_line;
    bit                     at_line_start;
    bit                     on_directive;
    int                     indent_count;
    bit [INDENT_DEPTH-1:0]  indent_tab;
    int                     step_results;

    // Clock generation.
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Model state after reset and after every end of text.
    function automatic void clear_blanker();
        lex_state     = LEX_TEXT;
        quote_single  = 1'b0;
        slash_pending = 1'b0;
        line_no       = LINE_BITS'(1);
        cmt_line      = '0;
        at_line_start = 1'b1;
        on_directive  = 1'b0;
        indent_count  = 0;
        indent_tab    = '0;
    endfunction

    function automatic void emit(logic [7:0] b, logic has);
        blanked_t r;
        r          = '0;
        r.out_byte = has ? b : 8'h00;
        r.has_byte = has;
        blanked_q.push_back(r);
        step_results++;
    endfunction

    // Releases the buffered leading blanks, as spaces on a directive line.
    function automatic void flush_indent(bit as_space);
        for (int i = 0; i < indent_count; i++)
            emit((as_space || !indent_tab[i]) ? CH_SPACE : CH_TAB, 1'b1);
        indent_count = 0;
    endfunction

    // Line stage: indent buffering and directive blanking.
    function automatic void line_put(logic [7:0] b);
        if (b == CH_NL)
        begin
            flush_indent(1'b0);
            emit(CH_NL, 1'b1);
            at_line_start = 1'b1;
            on_directive  = 1'b0;
            return;
        end
        if (on_directive)
        begin
            emit(CH_SPACE, 1'b1);
            return;
        end
        if (at_line_start)
        begin
            if (b == CH_SPACE || b == CH_TAB)
            begin
                if (indent_count < INDENT_DEPTH)
                begin
                    indent_tab[indent_count] = (b == CH_TAB);
                    indent_count++;
                end
                else
                begin
                    flush_indent(1'b0);
                    emit(b, 1'b1);
                end
                return;
            end
            at_line_start = 1'b0;
            if (b == CH_HASH)
            begin
                on_directive = 1'b1;
                flush_indent(1'b1);
                emit(CH_SPACE, 1'b1);
                return;
            end
            flush_indent(1'b0);
        end
        emit(b, 1'b1);
    endfunction

    // Lexer: comments, literals and the held slash.
    function automatic void lex_put(logic [7:0] c);
        case (lex_state)
            LEX_LINECMT:
            begin
                if (c == CH_NL)
                begin
                    line_put(CH_NL);
                    lex_state = LEX_TEXT;
                end
                else
                begin
                    line_put(CH_SPACE);
                end
            end
            LEX_BLOCK, LEX_STAR:
            begin
                if (c == CH_NL)
                begin
                    line_put(CH_NL);
                    lex_state = LEX_BLOCK;
                end
                else
                begin
                    line_put(CH_SPACE);
                    if (c == CH_STAR)
                        lex_state = LEX_STAR;
                    else if (c == CH_SLASH && lex_state == LEX_STAR)
                        lex_state = LEX_TEXT;
                    else
                        lex_state = LEX_BLOCK;
                end
            end
            LEX_STR:
            begin
                if (c == CH_NL)
                begin
                    line_put(CH_NL);
                end
                else if (c == CH_BSLASH)
                begin
                    line_put(CH_SPACE);
                    lex_state = LEX_ESC;
                end
                else if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE))
                begin
                    line_put(c);
                    lex_state = LEX_TEXT;
                end
                else
                begin
                    line_put(CH_SPACE);
                end
            end
            LEX_ESC:
            begin
                line_put((c == CH_NL) ? CH_NL : CH_SPACE);
                lex_state = LEX_STR;
            end
            default:
            begin
                lex_state = LEX_TEXT;
                if (slash_pending)
                begin
                    slash_pending = 1'b0;
                    if (c == CH_SLASH)
                    begin
                        line_put(CH_SPACE);
                        line_put(CH_SPACE);
                        lex_state = LEX_LINECMT;
                        return;
                    end
                    if (c == CH_STAR)
                    begin
                        line_put(CH_SPACE);
                        line_put(CH_SPACE);
                        cmt_line  = line_no;
                        lex_state = LEX_BLOCK;
                        return;
                    end
                    line_put(CH_SLASH);
                end
                if (c == CH_SLASH)
                begin
                    slash_pending = 1'b1;
                end
                else if (c == CH_DQUOTE || c == CH_SQUOTE)
                begin
                    quote_single = (c == CH_SQUOTE);
                    line_put(c);
                    lex_state = LEX_STR;
                end
                else
                begin
                    line_put(c);
                end
            end
        endcase
    endfunction

    // Predicts every result caused by one accepted source byte.
    function automatic void blank_byte(logic [7:0] c, logic last);
        bit                   open_cmt;
        logic [LINE_BITS-1:0] eline;
        step_results = 0;
        lex_put(c);
        if (c == CH_NL && line_no != LINE_TOP)
            line_no++;
        if (last)
        begin
            open_cmt = (lex_state == LEX_BLOCK || lex_state == LEX_STAR);
            eline    = cmt_line;
            if (slash_pending)
            begin
                slash_pending = 1'b0;
                line_put(CH_SLASH);
            end
            flush_indent(1'b0);
            if (step_results == 0)
                emit(8'h00, 1'b0);
            if (open_cmt)
            begin
                blanked_q[blanked_q.size() - 1].open_comment_error = 1'b1;
                blanked_q[blanked_q.size() - 1].error_line         = eline;
            end
            clear_blanker();
        end
        if (step_results > 0)
            blanked_q[blanked_q.size() - 1].run_end = 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        error_count++;
    endtask

    // Compares one result transfer with the oldest prediction.
    task automatic check_result();
        blanked_t want;
        if (blanked_q.size() == 0)
        begin
            report_mismatch("result with nothing pending", 32'(text_out.out_byte), 0);
            return;
        end
        want = blanked_q.pop_front();
        if (text_out.out_byte !== want.out_byte)
            report_mismatch("out_byte", 32'(text_out.out_byte), 32'(want.out_byte));
        if (text_out.has_byte !== want.has_byte)
            report_mismatch("has_byte", 32'(text_out.has_byte), 32'(want.has_byte));
        if (text_out.run_end !== want.run_end)
            report_mismatch("run_end", 32'(text_out.run_end), 32'(want.run_end));
        if (text_out.open_comment_error !== want.open_comment_error)
            report_mismatch("open_comment_error", 32'(text_out.open_comment_error),
                            32'(want.open_comment_error));
        if (text_out.error_line !== want.error_line)
            report_mismatch("error_line", 32'(text_out.error_line), 32'(want.error_line));
    endtask

    // Stimulus helpers.
    task automatic add(logic [7:0] b);
        source_byte_t s;
        s.text_byte = b;
        s.last      = 1'b0;
        s.wait_idle = next_idle;
        next_idle   = 1'b0;
        source_q.push_back(s);
    endtask

    task automatic end_text();
        source_q[source_q.size() - 1].last = 1'b1;
    endtask

    function automatic logic [7:0] letter();
        return 8'($urandom_range(32'(LOWER_A), 32'(LOWER_Z)));
    endfunction

    function automatic logic [7:0] special_char();
        case ($urandom_range(0, 8))
            0: return CH_SLASH;
            1: return CH_STAR;
            2: return CH_HASH;
            3: return CH_NL;
            4: return CH_SPACE;
            5: return CH_TAB;
            6: return CH_BSLASH;
            7: return CH_DQUOTE;
            default: return CH_SQUOTE;
        endcase
    endfunction

    task automatic add_word();
        repeat ($urandom_range(1, 5)) add(letter());
    endtask

    // Both channels are sampled here; results are checked before the new byte is predicted.
    always @(posedge clk)
    begin
        in_fire  = rst_n && text_in.valid && text_in.ready;
        out_fire = rst_n && text_out.valid && text_out.ready;
        if (out_fire)
            check_result();
        if (in_fire)
        begin
            blank_byte(text_in.in_byte, text_in.end_of_text);
            inputs_taken++;
        end
    end

    // Source side: offers the queued bytes with random gaps and waits for idle where asked.
    always @(negedge clk)
    begin
        if (rst_n && !(text_in.valid && !in_fire))
        begin
            if (text_in.valid)
            begin
                if ($urandom_range(0, 29) == 0)
                    src_burst = !src_burst;
                src_gap = src_burst ? 0 : $urandom_range(0, 3);
            end
            if (src_gap > 0)
            begin
                src_gap--;
                text_in.valid <= 1'b0;
            end
            else if (source_q.size() != 0 &&
                     !(source_q[0].wait_idle && blanked_q.size() != 0))
            begin
                sent = source_q.pop_front();
                text_in.valid       <= 1'b1;
                text_in.in_byte     <= sent.text_byte;
                text_in.end_of_text <= sent.last;
            end
            else
            begin
                text_in.valid <= 1'b0;
            end
        end
    end

    // Result side: random stalls per transfer, plus two long hold-offs that back up the block.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((stall_idx == 0 && inputs_taken >= STALL_FIRST) ||
                (stall_idx == 1 && inputs_taken >= STALL_SECOND))
            begin
                stall_left = STALL_CYCLES;
                stall_idx++;
            end
            if (out_fire)
            begin
                if ($urandom_range(0, 29) == 0)
                    sink_burst = !sink_burst;
                sink_gap = sink_burst ? 0 : $urandom_range(0, 3);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                text_out.ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                text_out.ready <= 1'b0;
            end
            else
            begin
                text_out.ready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int          nlines;
        int          ntok;
        int          n;
        int          base;
        bit          line_done;
        logic [7:0]  q;

        text_in.valid       = 1'b0;
        text_in.in_byte     = '0;
        text_in.end_of_text = 1'b0;
        text_out.ready      = 1'b0;
        rst_n               = 1'b0;
        clear_blanker();

        // Block comment opened on line two and never closed.
        add(CH_NL); add(CH_SLASH); add(CH_STAR); add(CH_NL); add(letter());
        end_text();
        // Indented directive: its blanks and its quote turn into spaces.
        add(CH_SPACE); add(CH_TAB); add(CH_HASH); add(CH_DQUOTE); add(CH_NL); add(letter());
        end_text();
        // Escaped quote in a character literal, a line comment, then a string left open.
        add(CH_SQUOTE); add(CH_BSLASH); add(CH_SQUOTE); add(CH_SQUOTE);
        add(CH_SLASH); add(CH_SLASH); add(letter()); add(CH_NL);
        add(CH_DQUOTE); add(8'hFF);
        end_text();
        // A slash still held at end of text.
        add(CH_SLASH);
        end_text();
        // Leading blanks still buffered at end of text.
        add(CH_TAB); add(CH_SPACE);
        end_text();
        // A carriage return ends the indent like any other byte.
        add(CH_SPACE); add(CH_CR);
        end_text();

        // Random texts: mostly C-like lines, some raw noise.
        base = source_q.size();
        while (source_q.size() - base < RANDOM_ITEMS)
        begin
            next_idle = (source_q.size() == base) || ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(3, 20);
                repeat (n) add($urandom_range(0, 1) ? special_char() : 8'($urandom_range(0, 255)));
            end
            else
            begin
                nlines = $urandom_range(1, 3);
                for (int l = 0; l < nlines; l++)
                begin
                    // Indent, now and then deep enough to overflow the buffer.
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 4);
                    repeat (n) add($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
                    if ($urandom_range(0, 4) == 0)
                    begin
                        add(CH_HASH);
                        add_word();
                        add(CH_SPACE);
                        if ($urandom_range(0, 1))
                        begin
                            add(CH_DQUOTE); add_word(); add(CH_DQUOTE);
                        end
                        else
                        begin
                            add(CH_SLASH); add(CH_STAR); add_word(); add(CH_STAR); add(CH_SLASH);
                        end
                    end
                    else
                    begin
                        ntok      = $urandom_range(1, 4);
                        line_done = 1'b0;
                        for (int t = 0; t < ntok && !line_done; t++)
                        begin
                            case ($urandom_range(0, 8))
                                0, 1: add_word();
                                2:
                                begin
                                    add(CH_SLASH); add(CH_STAR);
                                    repeat ($urandom_range(0, 4))
                                        add($urandom_range(0, 1) ? special_char() : letter());
                                    add(CH_STAR); add(CH_SLASH);
                                end
                                3:
                                begin
                                    add(CH_SLASH); add(CH_SLASH); add_word();
                                    line_done = 1'b1;
                                end
                                4, 5:
                                begin
                                    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                                    add(q);
                                    repeat ($urandom_range(0, 4))
                                    begin
                                        if ($urandom_range(0, 2) == 0)
                                        begin
                                            add(CH_BSLASH);
                                            add(special_char());
                                        end
                                        else
                                        begin
                                            add($urandom_range(0, 1) ? letter() : special_char());
                                        end
                                    end
                                    if ($urandom_range(0, 9) != 0)
                                        add(q);
                                end
                                6:
                                begin
                                    add($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
                                    add($urandom_range(0, 1) ? CH_SPACE : letter());
                                end
                                7: add(special_char());
                                default: add(8'($urandom_range(0, 255)));
                            endcase
                        end
                    end
                    if (l < nlines - 1 || $urandom_range(0, 1))
                        add(CH_NL);
                end
                // Now and then the text ends inside a block comment.
                if ($urandom_range(0, 5) == 0)
                begin
                    add(CH_SLASH); add(CH_STAR); add_word();
                end
            end
            end_text();
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (source_q.size() != 0 || text_in.valid)
            @(posedge clk);
        while (blanked_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("c_source_noise_blanker_test: PASS");
        else
            $display("c_source_noise_blanker_test: FAIL");
        $finish;
    end

    // Watchdog for a hung block.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("c_source_noise_blanker_test: FAIL");
        $finish;
    end

endmodule

FILE: c_source_noise_blanker.f
+incdir+hw/rtl
hw/rtl/cnb_pkg.sv
hw/rtl/cnb_in_if.sv
hw/rtl/cnb_out_if.sv
hw/rtl/cnb_front.sv
hw/rtl/cnb_queue.sv
hw/rtl/cnb_back.sv
hw/rtl/c_source_noise_blanker.sv
tb/sv/c_source_noise_blanker_test.sv
